FILE: sv/rfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared constants and types for the radial force accumulator.
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int PARTICLE_COUNT = 128;
    localparam int A_W            = $clog2(PARTICLE_COUNT);
    localparam int CNT_W          = $clog2(PARTICLE_COUNT + 1);

    localparam int SQRT_STEPS = 20;
    localparam int RAD_W      = 40;
    localparam int ROOT_W     = 20;
    localparam int MAG_W      = 62;
    localparam int DEN_W      = 40;
    localparam int STEP_W     = $clog2(MAG_W);

    typedef enum logic [1:0] {
        CMD_WRITE_POS = 2'd0,
        CMD_CLEAR     = 2'd1,
        CMD_APPLY     = 2'd2,
        CMD_READ      = 2'd3
    } t_cmd;

    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BIN_SHIFT   = 2'd2;

    localparam logic [11:0] GRID_WIDTH_RST  = 12'd1024;
    localparam logic [11:0] GRID_HEIGHT_RST = 12'd768;
    localparam logic [3:0]  BIN_SHIFT_RST   = 4'd4;

endpackage

FILE: sv/rfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: sv/radial_force_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_force_accumulate
// Particle position and force store with a radial force scan.
// ----------------------------------------------------------------------------
// Write position and clear forces answer straight from idle; read force goes
// through S_READ first. Apply force walks all 128 particles one at a time
// through the position and force RAMs: a particle outside the grid passes
// S_FETCH and S_GRID, one that misses the radius also S_SQUARE and S_DIST,
// and a hit goes on through the square root loop, S_MUL1, S_MUL2, the shared
// bit-serial divider once per component and S_WB. An apply keeps busy high
// throughout. The result strobe lasts one cycle and cannot be held off; busy
// is low while a new command can be taken, and no start-up clearing is needed.
// ----------------------------------------------------------------------------
module radial_force_accumulate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic [6:0]         i_particle_index,
    input  logic [15:0]        i_new_x,
    input  logic [15:0]        i_new_y,
    input  logic signed [16:0] i_target_x,
    input  logic signed [16:0] i_target_y,
    input  logic [15:0]        i_radius,
    input  logic signed [15:0] i_scale,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    output logic               o_result_valid,
    output logic signed [31:0] o_force_x_out,
    output logic signed [31:0] o_force_y_out,
    output logic [7:0]         o_affected_count
);

    import rfa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_FETCH, S_GRID, S_SQUARE, S_DIST,
        S_SQRT, S_MUL1, S_MUL2, S_DIVX, S_DIVY, S_WB
    } t_state;

    t_state r_state;

    logic [11:0] r_grid_w, r_grid_h;
    logic [3:0]  r_bin_shift;

    logic [A_W-1:0]         r_idx;
    logic                   r_idx_ok;
    logic signed [16:0]     r_tx, r_ty;
    logic [ROOT_W-1:0]      r_rq8;
    logic [31:0]            r_r2;
    logic [15:0]            r_scl_mag;
    logic                   r_scl_neg;
    logic [16:0]            r_xbins, r_ybins;
    logic [PARTICLE_COUNT-1:0] r_fvalid;

    logic signed [17:0]     r_dx, r_dy;
    logic [35:0]            r_dx2, r_dy2;
    logic [RAD_W-1:0]       r_sq_v, r_sq_res, r_sq_bit;
    logic [STEP_W-1:0]      r_step;
    logic [37:0]            r_px, r_py;
    logic [DEN_W-1:0]       r_den;
    logic [MAG_W-1:0]       r_magy, r_qx;
    logic [MAG_W-1:0]       r_div_q;
    logic [DEN_W-1:0]       r_div_rem;
    logic [7:0]             r_count;

    logic                   w_accept, w_last, w_idx_ok, w_in_grid;
    logic [A_W-1:0]         w_addr;
    logic [31:0]            w_pos_rd;
    logic [63:0]            w_force_rd;
    logic signed [31:0]     w_fx_cur, w_fy_cur, w_fx_new, w_fy_new;
    logic                   w_pos_we, w_force_we;
    logic signed [17:0]     w_dx, w_dy;
    logic [16:0]            w_bsize;
    logic [36:0]            w_d2;
    logic [RAD_W:0]         w_sq_t;
    logic [ROOT_W-1:0]      w_root, w_diff;
    logic [17:0]            w_ax, w_ay;
    logic [DEN_W:0]         w_trial;
    logic [MAG_W-1:0]       n_div_q;
    logic [DEN_W-1:0]       n_div_rem;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                   input logic [MAG_W-1:0] q,
                                                   input logic neg);
        logic signed [63:0] s;
        logic signed [63:0] qs;
        qs = $signed({2'b00, q});
        s  = {{32{acc[31]}}, acc};
        s  = neg ? s - qs : s + qs;
        if (s > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (s < -64'sh0000_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_idx_ok    = 32'(i_particle_index) < PARTICLE_COUNT;
    assign w_addr      = (r_state == S_IDLE) ? A_W'(i_particle_index) : r_idx;
    assign w_last      = (r_idx == A_W'(PARTICLE_COUNT - 1));
    assign w_bsize     = 17'd1 << r_bin_shift;

    assign w_pos_we = w_accept && (i_cmd == CMD_WRITE_POS) && w_idx_ok;

    rfa_ram #(.WIDTH(32), .DEPTH(PARTICLE_COUNT)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_pos_we),
        .i_waddr (w_addr),
        .i_wdata ({i_new_x, i_new_y}),
        .i_raddr (w_addr),
        .o_rdata (w_pos_rd)
    );

    assign w_force_we = (r_state == S_WB);

    rfa_ram #(.WIDTH(64), .DEPTH(PARTICLE_COUNT)) u_force_ram (
        .i_clk   (i_clk),
        .i_we    (w_force_we),
        .i_waddr (w_addr),
        .i_wdata ({w_fx_new, w_fy_new}),
        .i_raddr (w_addr),
        .o_rdata (w_force_rd)
    );

    // entries not written since reset or the last clear read as zero
    assign w_fx_cur = r_fvalid[w_addr] ? w_force_rd[63:32] : 32'sd0;
    assign w_fy_cur = r_fvalid[w_addr] ? w_force_rd[31:0]  : 32'sd0;
    assign w_fx_new = sat_add(w_fx_cur, r_qx, r_dx[17] ^ r_scl_neg);
    assign w_fy_new = sat_add(w_fy_cur, r_div_q, r_dy[17] ^ r_scl_neg);

    assign w_dx = $signed({2'b00, w_pos_rd[31:16]}) - $signed({r_tx[16], r_tx});
    assign w_dy = $signed({2'b00, w_pos_rd[15:0]})  - $signed({r_ty[16], r_ty});
    assign w_in_grid = (17'(w_pos_rd[31:20] >> r_bin_shift) < r_xbins)
                    && (17'(w_pos_rd[15:4] >> r_bin_shift) < r_ybins);

    assign w_d2   = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign w_sq_t = {1'b0, r_sq_res} + {1'b0, r_sq_bit};
    assign w_root = r_sq_res[ROOT_W-1:0];
    assign w_diff = r_rq8 - w_root;
    assign w_ax   = r_dx[17] ? 18'(-r_dx) : 18'(r_dx);
    assign w_ay   = r_dy[17] ? 18'(-r_dy) : 18'(r_dy);

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_div_rem, r_div_q[MAG_W-1]};
    always_comb begin
        if (w_trial >= {1'b0, r_den}) begin
            n_div_rem = DEN_W'(w_trial - {1'b0, r_den});
            n_div_q   = {r_div_q[MAG_W-2:0], 1'b1};
        end else begin
            n_div_rem = w_trial[DEN_W-1:0];
            n_div_q   = {r_div_q[MAG_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_grid_w         <= GRID_WIDTH_RST;
            r_grid_h         <= GRID_HEIGHT_RST;
            r_bin_shift      <= BIN_SHIFT_RST;
            r_fvalid         <= '0;
            r_idx            <= '0;
            r_step           <= '0;
            r_count          <= '0;
            o_result_valid   <= 1'b0;
            o_force_x_out    <= '0;
            o_force_y_out    <= '0;
            o_affected_count <= '0;
        end else begin
            o_result_valid <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GRID_WIDTH:  r_grid_w    <= i_cfg_data;
                    CFG_GRID_HEIGHT: r_grid_h    <= i_cfg_data;
                    CFG_BIN_SHIFT:   r_bin_shift <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx_ok  <= w_idx_ok;
                        r_tx      <= i_target_x;
                        r_ty      <= i_target_y;
                        r_rq8     <= {i_radius, 4'h0};
                        r_r2      <= i_radius * i_radius;
                        r_scl_neg <= i_scale[15];
                        r_scl_mag <= i_scale[15] ? 16'(-i_scale) : 16'(i_scale);
                        r_xbins   <= 17'(({5'd0, r_grid_w} + w_bsize - 17'd1) >> r_bin_shift);
                        r_ybins   <= 17'(({5'd0, r_grid_h} + w_bsize - 17'd1) >> r_bin_shift);
                        r_idx     <= (i_cmd == CMD_READ) ? A_W'(i_particle_index) : '0;
                        r_count   <= '0;
                        case (i_cmd)
                            CMD_WRITE_POS, CMD_CLEAR: begin
                                if (i_cmd == CMD_CLEAR) begin
                                    r_fvalid <= '0;
                                end
                                o_result_valid   <= 1'b1;
                                o_force_x_out    <= '0;
                                o_force_y_out    <= '0;
                                o_affected_count <= '0;
                            end
                            CMD_APPLY: r_state <= S_FETCH;
                            CMD_READ:  r_state <= S_READ;
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    o_result_valid   <= 1'b1;
                    o_force_x_out    <= r_idx_ok ? w_fx_cur : 32'sd0;
                    o_force_y_out    <= r_idx_ok ? w_fy_cur : 32'sd0;
                    o_affected_count <= '0;
                    r_state          <= S_IDLE;
                end
                S_FETCH: begin
                    r_state <= S_GRID;
                end
                S_GRID: begin
                    r_dx <= w_dx;
                    r_dy <= w_dy;
                    if (w_in_grid) begin
                        r_state <= S_SQUARE;
                    end else if (w_last) begin
                        o_result_valid   <= 1'b1;
                        o_force_x_out    <= '0;
                        o_force_y_out    <= '0;
                        o_affected_count <= r_count;
                        r_state          <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + A_W'(1);
                        r_state <= S_FETCH;
                    end
                end
                S_SQUARE: begin
                    r_dx2   <= 36'(r_dx) * 36'(r_dx);
                    r_dy2   <= 36'(r_dy) * 36'(r_dy);
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    r_sq_v   <= {w_d2[31:0], 8'h00};
                    r_sq_res <= '0;
                    r_sq_bit <= RAD_W'(1) << (RAD_W - 2);
                    r_step   <= '0;
                    if ((w_d2 != '0) && (w_d2 < {5'd0, r_r2})) begin
                        r_state <= S_SQRT;
                    end else if (w_last) begin
                        o_result_valid   <= 1'b1;
                        o_force_x_out    <= '0;
                        o_force_y_out    <= '0;
                        o_affected_count <= r_count;
                        r_state          <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + A_W'(1);
                        r_state <= S_FETCH;
                    end
                end
                S_SQRT: begin
                    if ({1'b0, r_sq_v} >= w_sq_t) begin
                        r_sq_v   <= RAD_W'({1'b0, r_sq_v} - w_sq_t);
                        r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                    end else begin
                        r_sq_res <= r_sq_res >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                    r_step   <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_px    <= w_ax * w_diff;
                    r_py    <= w_ay * w_diff;
                    r_den   <= w_root * r_rq8;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_div_q   <= (MAG_W'(r_px) * MAG_W'(r_scl_mag)) << 8;
                    r_magy    <= (MAG_W'(r_py) * MAG_W'(r_scl_mag)) << 8;
                    r_div_rem <= '0;
                    r_step    <= '0;
                    r_state   <= S_DIVX;
                end
                S_DIVX: begin
                    if (r_step == STEP_W'(MAG_W - 1)) begin
                        r_qx      <= n_div_q;
                        r_div_q   <= r_magy;
                        r_div_rem <= '0;
                        r_step    <= '0;
                        r_state   <= S_DIVY;
                    end else begin
                        r_div_q   <= n_div_q;
                        r_div_rem <= n_div_rem;
                        r_step    <= r_step + STEP_W'(1);
                    end
                end
                S_DIVY: begin
                    r_div_q   <= n_div_q;
                    r_div_rem <= n_div_rem;
                    r_step    <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(MAG_W - 1)) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_fvalid[w_addr] <= 1'b1;
                    if (w_last) begin
                        o_result_valid   <= 1'b1;
                        o_force_x_out    <= '0;
                        o_force_y_out    <= '0;
                        o_affected_count <= (r_count == 8'hFF) ? r_count : r_count + 8'd1;
                        r_state          <= S_IDLE;
                    end else begin
                        r_count <= (r_count == 8'hFF) ? r_count : r_count + 8'd1;
                        r_idx   <= r_idx + A_W'(1);
                        r_state <= S_FETCH;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVX || r_state == S_DIVY) |-> (r_den != '0))
        else $error("divider started with zero divisor");

    a_root_below_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL1) |-> (w_root < r_rq8))
        else $error("distance not below radius on a hit");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd == CMD_CLEAR) |=> (r_fvalid == '0))
        else $error("force clear left valid entries");

    a_sqrt_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_step < STEP_W'(SQRT_STEPS)))
        else $error("square root ran past its step count");
`endif

endmodule

FILE: tb/sv/force_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// force_scoreboard
// Watches the command, configuration and result channels of the radial force
// accumulator, keeps its own copy of the particle and force stores, predicts
// each result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module force_scoreboard
    import rfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_cmd,
    input  logic [6:0]         i_particle_index,
    input  logic [15:0]        i_new_x,
    input  logic [15:0]        i_new_y,
    input  logic signed [16:0] i_target_x,
    input  logic signed [16:0] i_target_y,
    input  logic [15:0]        i_radius,
    input  logic signed [15:0] i_scale,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    input  logic               i_result_valid,
    input  logic signed [31:0] i_force_x_out,
    input  logic signed [31:0] i_force_y_out,
    input  logic [7:0]         i_affected_count,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic [7:0]         count;
    } t_force_result;

    t_force_result      expected_q[$];
    logic [11:0]        grid_w;
    logic [11:0]        grid_h;
    logic [3:0]         shift;
    logic [15:0]        pos_x[PARTICLE_COUNT];
    logic [15:0]        pos_y[PARTICLE_COUNT];
    logic signed [31:0] acc_x[PARTICLE_COUNT];
    logic signed [31:0] acc_y[PARTICLE_COUNT];

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint force_part(longint off, longint scl, longint unsigned d,
                                          longint unsigned r);
        longint unsigned a;
        longint unsigned s;
        longint unsigned q;
        a = (off < 0) ? -off : off;
        s = (scl < 0) ? -scl : scl;
        q = (a * 16 * (r - d) * s * 16) / (d * r);
        return ((off < 0) != (scl < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [31:0] sat_acc(logic signed [31:0] acc, longint add);
        longint s;
        s = longint'(acc) + add;
        if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (s < -64'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic t_force_result predict_force();
        t_force_result   r;
        longint          dx, dy, tx, ty, scl;
        longint unsigned d2, d, r2, rq, bsize, xbins, ybins;
        r = '0;
        case (t_cmd'(i_cmd))
            CMD_WRITE_POS: begin
                pos_x[i_particle_index] = i_new_x;
                pos_y[i_particle_index] = i_new_y;
            end
            CMD_CLEAR: begin
                for (int i = 0; i < PARTICLE_COUNT; i++) begin
                    acc_x[i] = '0;
                    acc_y[i] = '0;
                end
            end
            CMD_APPLY: begin
                tx = i_target_x;
                ty = i_target_y;
                scl = i_scale;
                r2 = longint'(i_radius) * longint'(i_radius);
                rq = longint'(i_radius) << 4;
                bsize = 64'd1 << shift;
                xbins = (grid_w + bsize - 1) >> shift;
                ybins = (grid_h + bsize - 1) >> shift;
                for (int i = 0; i < PARTICLE_COUNT; i++) begin
                    if (((longint'(pos_x[i]) >> 4) >> shift) >= xbins) continue;
                    if (((longint'(pos_y[i]) >> 4) >> shift) >= ybins) continue;
                    dx = longint'(pos_x[i]) - tx;
                    dy = longint'(pos_y[i]) - ty;
                    d2 = dx * dx + dy * dy;
                    if (d2 == 0 || d2 >= r2) continue;
                    d = isqrt(d2 << 8);
                    acc_x[i] = sat_acc(acc_x[i], force_part(dx, scl, d, rq));
                    acc_y[i] = sat_acc(acc_y[i], force_part(dy, scl, d, rq));
                    if (r.count != 8'd255) r.count = r.count + 8'd1;
                end
            end
            default: begin
                r.fx = acc_x[i_particle_index];
                r.fy = acc_y[i_particle_index];
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_force_result e;
        if (!i_rst_n) begin
            grid_w = GRID_WIDTH_RST;
            grid_h = GRID_HEIGHT_RST;
            shift = BIN_SHIFT_RST;
            for (int i = 0; i < PARTICLE_COUNT; i++) begin
                pos_x[i] = '0;
                pos_y[i] = '0;
                acc_x[i] = '0;
                acc_y[i] = '0;
            end
            expected_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GRID_WIDTH:  grid_w = i_cfg_data;
                    CFG_GRID_HEIGHT: grid_h = i_cfg_data;
                    CFG_BIN_SHIFT:   shift = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_result_valid) begin
                if (expected_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result fx=%0d fy=%0d count=%0d",
                                 i_force_x_out, i_force_y_out, i_affected_count);
                end else begin
                    e = expected_q.pop_front();
                    if (e.fx !== i_force_x_out || e.fy !== i_force_y_out ||
                        e.count !== i_affected_count) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"mismatch: expected fx=%0d fy=%0d count=%0d, ",
                                      "got fx=%0d fy=%0d count=%0d"},
                                     e.fx, e.fy, e.count, i_force_x_out, i_force_y_out,
                                     i_affected_count);
                    end
                end
            end
            if (i_start && !i_busy) expected_q.insert(expected_q.size(), predict_force());
        end
        o_pending = expected_q.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives commands and register writes into the radial force accumulator over
// four idling phases and grid settings, with a scoreboard checking results.
// ----------------------------------------------------------------------------
module testbench;
    import rfa_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_cmd = '0;
    logic [6:0]         i_particle_index = '0;
    logic [15:0]        i_new_x = '0;
    logic [15:0]        i_new_y = '0;
    logic signed [16:0] i_target_x = '0;
    logic signed [16:0] i_target_y = '0;
    logic [15:0]        i_radius = '0;
    logic signed [15:0] i_scale = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [11:0]        i_cfg_data = '0;
    logic               o_result_valid;
    logic signed [31:0] o_force_x_out;
    logic signed [31:0] o_force_y_out;
    logic [7:0]         o_affected_count;
    int                 errors;
    int                 pending;
    int                 idle_pct;

    always #10 i_clk = ~i_clk;

    radial_force_accumulate DUT (.*);

    force_scoreboard u_scoreboard (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_cmd, .i_particle_index,
        .i_new_x, .i_new_y, .i_target_x, .i_target_y, .i_radius, .i_scale,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_result_valid(o_result_valid), .i_force_x_out(o_force_x_out),
        .i_force_y_out(o_force_y_out), .i_affected_count(o_affected_count),
        .o_errors(errors), .o_pending(pending)
    );

    task automatic issue(t_cmd c, logic [6:0] idx, logic [15:0] nx, logic [15:0] ny,
                         logic [16:0] tx, logic [16:0] ty, logic [15:0] rad,
                         logic [15:0] scl);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        i_particle_index <= idx;
        i_new_x <= nx;
        i_new_y <= ny;
        i_target_x <= tx;
        i_target_y <= ty;
        i_radius <= rad;
        i_scale <= scl;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic set_grid(logic [11:0] w, logic [11:0] h, logic [11:0] s);
        write_reg(CFG_GRID_WIDTH, w);
        write_reg(CFG_GRID_HEIGHT, h);
        write_reg(CFG_BIN_SHIFT, s);
        @(posedge i_clk);
    endtask

    // mostly clustered positions and targets so that forces actually land
    function automatic logic [15:0] near_pos();
        return ($urandom_range(99) < 75) ? 16'($urandom_range(4800, 1600))
                                         : 16'($urandom);
    endfunction

    task automatic random_item();
        int           sel;
        logic [15:0]  rad;
        sel = $urandom_range(99);
        rad = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1200));
        if (sel < 45)
            issue(CMD_WRITE_POS, 7'($urandom), near_pos(), near_pos(), '0, '0, '0, '0);
        else if (sel < 50)
            issue(CMD_CLEAR, 7'($urandom), 16'($urandom), 16'($urandom), '0, '0, '0, '0);
        else if (sel < 65)
            issue(CMD_APPLY, 7'($urandom), 16'($urandom), 16'($urandom),
                  ($urandom_range(9) == 0) ? 17'($urandom) : 17'(near_pos()),
                  ($urandom_range(9) == 0) ? 17'($urandom) : 17'(near_pos()),
                  rad, 16'($urandom));
        else
            issue(CMD_READ, 7'($urandom), 16'($urandom), 16'($urandom),
                  17'($urandom), 17'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        idle_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every position written before any force is applied
        for (int i = 0; i < PARTICLE_COUNT; i++)
            issue(CMD_WRITE_POS, 7'(i), near_pos(), near_pos(), '0, '0, '0, '0);
        issue(CMD_WRITE_POS, 7'd0, 16'd0, 16'd0, '0, '0, '0, '0);
        issue(CMD_WRITE_POS, 7'd127, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0);
        issue(CMD_WRITE_POS, 7'd5, 16'd3200, 16'd3200, '0, '0, '0, '0);
        issue(CMD_APPLY, '0, '0, '0, 17'd3200, 17'd3200, 16'd800, 16'sh7FFF);
        issue(CMD_APPLY, '0, '0, '0, 17'd3200, 17'd3200, 16'd0, 16'sh7FFF);
        issue(CMD_APPLY, '0, '0, '0, 17'd3300, 17'd3100, 16'hFFFF, -16'sd32768);
        issue(CMD_APPLY, '0, '0, '0, -17'sd65536, 17'sd65535, 16'hFFFF, 16'sh7FFF);
        issue(CMD_APPLY, '0, '0, '0, 17'sd65535, -17'sd65536, 16'd1, 16'sh0001);
        issue(CMD_READ, 7'd0, '0, '0, '0, '0, '0, '0);
        issue(CMD_READ, 7'd5, '0, '0, '0, '0, '0, '0);
        issue(CMD_READ, 7'd127, '0, '0, '0, '0, '0, '0);
        for (int i = 0; i < 4; i++)
            issue(CMD_APPLY, '0, '0, '0, 17'd3190, 17'd3210, 16'd400, 16'sh7FFF);
        issue(CMD_READ, 7'd5, '0, '0, '0, '0, '0, '0);
        issue(CMD_CLEAR, '0, '0, '0, '0, '0, '0, '0);
        issue(CMD_READ, 7'd5, '0, '0, '0, '0, '0, '0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  set_grid(12'd4095, 12'd4095, 12'd0); end
                1: begin idle_pct = 57; set_grid(12'd1, 12'd1, 12'd11); end
                2: begin idle_pct = 24; set_grid(12'd300, 12'd250, 12'd3); end
                default: begin
                    idle_pct = 57;
                    set_grid(12'($urandom_range(4095, 1)), 12'($urandom_range(4095, 1)),
                             12'($urandom_range(11)));
                end
            endcase
            for (int n = 0; n < 36; n++) random_item();
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #400ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
